// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the calibration pipeline.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while reset is held.
`define SSDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SSDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ssdc_pkg.sv -----
package ssdc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int LOG_TABLE_BITS = 8;
  localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;

  // Power word: square of the sample plus the 32-bit noise term.
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int P_W   = ((SQ_W > 32) ? SQ_W : 32) + 1;
  localparam int E_W   = $clog2(P_W);
  // Q.16 log2 value and its product with 10*log10(2).
  localparam int L_W     = E_W + 16;
  localparam int K_W     = 18;
  localparam int PROD_W  = L_W + K_W;
  localparam int RAW_W   = PROD_W - 23;
  localparam int DB_W    = RAW_W + 2;

  localparam logic [K_W-1:0]      TEN_LOG10_2 = K_W'(197284);
  localparam logic [PROD_W-1:0]   DB_ROUND    = PROD_W'(1) << 23;
  localparam logic signed [DB_W-1:0] DB_FLOOR = DB_W'(-17920);
  localparam logic [15:0]         NORM_ONE    = 16'd32768;

  typedef enum logic [2:0] {
    REG_NOISE_POWER   = 3'd0,
    REG_GAIN_DB       = 3'd1,
    REG_CLIP_LOW_DB   = 3'd2,
    REG_CLIP_HIGH_DB  = 3'd3,
    REG_NORM_FLOOR_DB = 3'd4,
    REG_NORM_SCALE    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] noise_power;
    logic [15:0] gain_db;
    logic [15:0] clip_low_db;
    logic [15:0] clip_high_db;
    logic [15:0] norm_floor_db;
    logic [15:0] norm_scale;
  } cfg_t;

  // Front end result: exponent and mantissa index of the power word.
  typedef struct packed {
    logic                      use_low;
    logic [E_W-1:0]            e;
    logic [LOG_TABLE_BITS-1:0] idx;
  } front_t;

  typedef logic [TABLE_SIZE-1:0][15:0] log_table_t;

  // log2(1 + i/2^LOG_TABLE_BITS) in Q0.16, by repeated truncating squaring.
  function automatic log_table_t build_log_table();
    log_table_t  t;
    logic [63:0] x;
    logic [15:0] r;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      r = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = {r[14:0], 1'b0};
        if (x >= (64'd2 << 30)) begin
          r[0] = 1'b1;
          x = x >> 1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam log_table_t LOG_TABLE = build_log_table();

  function automatic logic signed [DB_W-1:0] sext_db(input logic [15:0] v);
    return $signed({{(DB_W - 16){v[15]}}, v});
  endfunction

endpackage

// ----- hw/rtl/sar_sigma0_db_calibration_unit.sv -----
// SAR sigma-nought calibration to dB, one pixel per transaction.
// Input stream (s_*): s_tdata carries the raw amplitude sample, s_tuser the
// bad-sample flag. Output stream (m_*): m_tdata carries the calibrated,
// clamped backscatter in signed Q8.8 dB and its normalized Q1.15 value.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data; an index
// beyond the register list is ignored. Write registers only while no pixel
// is in flight.
// The datapath is a nine-stage pipeline: square, noise add, leading-one
// search, mantissa shift, log table, log scaling multiply, gain and clamp,
// normalization multiply, rounding and saturation. An accepted pixel moves
// through these stages in order to m_tvalid. One pixel per cycle is sustained
// while m_tready is high, given a single multiplier or table per stage.
// Each stage has its own valid bit, and a stage loads whenever it is empty
// or the stage after it moves, so idle slots close up under a stall. When
// m_tready stays low the pipeline fills, nine pixels are held, and then
// s_tready drops; nothing is lost or repeated.
// Synchronous reset empties every stage and loads the register defaults.
module sar_sigma0_db_calibration_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] raw_sample
  input  logic        s_tuser,   // [0] sample_bad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] sigma_db, [31:16] sigma_norm
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ssdc_pkg::*;

  cfg_t        cfg;
  front_t      front_data;
  logic        front_valid, front_ready;
  logic        db_valid, db_ready;
  logic [15:0] db_value;
  logic [15:0] sigma_db, sigma_norm;

  // Configuration registers. Codes outside the list fall to the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_power   <= 32'd0;
      cfg.gain_db       <= 16'd0;
      cfg.clip_low_db   <= 16'hD800;
      cfg.clip_high_db  <= 16'd2560;
      cfg.norm_floor_db <= 16'hD800;
      cfg.norm_scale    <= 16'd1311;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_NOISE_POWER:   cfg.noise_power   <= cfg_data;
        REG_GAIN_DB:       cfg.gain_db       <= cfg_data[15:0];
        REG_CLIP_LOW_DB:   cfg.clip_low_db   <= cfg_data[15:0];
        REG_CLIP_HIGH_DB:  cfg.clip_high_db  <= cfg_data[15:0];
        REG_NORM_FLOOR_DB: cfg.norm_floor_db <= cfg_data[15:0];
        REG_NORM_SCALE:    cfg.norm_scale    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Power and its exponent and mantissa index.
  ssdc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .raw_sample  (s_tdata),
    .sample_bad  (s_tuser),
    .noise_power (cfg.noise_power),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .out_data    (front_data)
  );

  // Log conversion, gain, floor and clip window.
  ssdc_db u_db (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .cfg       (cfg),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .sigma_db  (db_value)
  );

  // Normalization and the output register.
  ssdc_norm u_norm (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (db_valid),
    .in_ready   (db_ready),
    .in_db      (db_value),
    .cfg        (cfg),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sigma_db   (sigma_db),
    .sigma_norm (sigma_norm)
  );

  assign m_tdata = {sigma_norm, sigma_db};

endmodule

// ----- hw/rtl/ssdc_front.sv -----
module ssdc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           raw_sample,
  input  logic                  sample_bad,
  input  logic [31:0]           noise_power,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssdc_pkg::front_t      out_data
);
  import ssdc_pkg::*;

  logic [SAMPLE_BITS-1:0]    dn;
  logic                      v1, v2, v3, v4;
  logic                      en1, en2, en3, en4;
  logic [SQ_W-1:0]           sq1;
  logic                      low1, low2, low3;
  logic [P_W-1:0]            p2, p3;
  logic [E_W-1:0]            e3;
  logic [E_W-1:0]            e3_next;
  logic [P_W+LOG_TABLE_BITS-1:0] shifted;
  front_t                    s4;

  assign dn = raw_sample[SAMPLE_BITS-1:0];

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  // Position of the leading one of the power word.
  always_comb begin
    e3_next = '0;
    for (int i = 0; i < P_W; i++) begin
      if (p2[i]) e3_next = E_W'(i);
    end
  end

  // Bits below the leading one, zero filled when the word is short.
  assign shifted = {p3, {LOG_TABLE_BITS{1'b0}}} >> e3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sq1  <= SQ_W'(dn) * SQ_W'(dn);
      low1 <= sample_bad || (dn == '0);
    end
    if (en2) begin
      p2   <= P_W'(sq1) + P_W'(noise_power);
      low2 <= low1;
    end
    if (en3) begin
      p3   <= p2;
      e3   <= e3_next;
      low3 <= low2;
    end
    if (en4) begin
      s4.use_low <= low3;
      s4.e       <= e3;
      s4.idx     <= shifted[LOG_TABLE_BITS-1:0];
    end
  end

  assign out_valid = v4;
  assign out_data  = s4;

endmodule

// ----- hw/rtl/ssdc_db.sv -----
module ssdc_db (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssdc_pkg::front_t in_data,
  input  ssdc_pkg::cfg_t   cfg,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      sigma_db
);
  import ssdc_pkg::*;

  logic                   v5, v6, v7;
  logic                   en5, en6, en7;
  logic [L_W-1:0]         l5;
  logic                   low5, low6;
  logic [PROD_W-1:0]      prod6;
  logic [PROD_W:0]        rounded;
  logic signed [DB_W-1:0] db_calc;
  logic signed [DB_W-1:0] lo_ext, hi_ext;
  logic [15:0]            db7;

  assign en7 = !v7 || out_ready;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign in_ready = en5;

  assign rounded = {1'b0, prod6} + {1'b0, DB_ROUND};
  assign lo_ext  = sext_db(cfg.clip_low_db);
  assign hi_ext  = sext_db(cfg.clip_high_db);

  // Gain removal, then the -70 dB floor, then the clip window (low first); flagged pixels get clip_low.
  always_comb begin
    db_calc = $signed({2'b00, rounded[PROD_W:24]}) - sext_db(cfg.gain_db);
    if (db_calc < DB_FLOOR) db_calc = DB_FLOOR;
    if (db_calc < lo_ext)   db_calc = lo_ext;
    if (db_calc > hi_ext)   db_calc = hi_ext;
    if (low6)               db_calc = lo_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en5) v5 <= in_valid;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      l5   <= {in_data.e, LOG_TABLE[in_data.idx]};
      low5 <= in_data.use_low;
    end
    if (en6) begin
      prod6 <= PROD_W'(l5) * PROD_W'(TEN_LOG10_2);
      low6  <= low5;
    end
    if (en7) begin
      db7 <= db_calc[15:0];
    end
  end

  assign out_valid = v7;
  assign sigma_db  = db7;

endmodule

// ----- hw/rtl/ssdc_norm.sv -----
`include "assert_macros.svh"

module ssdc_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    in_db,
  input  ssdc_pkg::cfg_t cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    sigma_db,
  output logic [15:0]    sigma_norm
);
  import ssdc_pkg::*;

  logic               v8, v9;
  logic               en8, en9;
  logic signed [16:0] d;
  logic               pos8;
  logic [31:0]        prod8;
  logic [15:0]        db8, db9;
  logic [32:0]        sum;
  logic [23:0]        q;
  logic [15:0]        norm_next;
  logic [15:0]        norm9;

  assign en9 = !v9 || out_ready;
  assign en8 = !v8 || en9;
  assign in_ready = en8;

  assign d = $signed({in_db[15], in_db}) - $signed({cfg.norm_floor_db[15], cfg.norm_floor_db});

  assign sum = {1'b0, prod8} + 33'd256;
  assign q   = sum[32:9];

  always_comb begin
    if (!pos8) begin
      norm_next = '0;
    end else if (q > 24'(NORM_ONE)) begin
      norm_next = NORM_ONE;
    end else begin
      norm_next = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (en8) v8 <= in_valid;
      if (en9) v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      db8   <= in_db;
      pos8  <= !d[16] && (d != '0);
      prod8 <= {16'b0, d[15:0]} * {16'b0, cfg.norm_scale};
    end
    if (en9) begin
      db9   <= db8;
      norm9 <= norm_next;
    end
  end

  assign out_valid  = v9;
  assign sigma_db   = db9;
  assign sigma_norm = norm9;

  `SSDC_ASSERT(a_norm_saturated, v9 |-> (norm9 <= NORM_ONE), "normalized value above one")
  `SSDC_ASSERT(a_hold_on_stall, (v9 && !out_ready) |=> ($stable(norm9) && $stable(db9)),
               "output register changed while stalled")
  `SSDC_ASSERT(a_no_phantom, (!v8 && !v9) |=> !v9, "output valid without a transaction behind it")
  `SSDC_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> (!v8 && !v9), "pipeline valid after reset")

endmodule
